// ----- hw/rtl/tcfw_pkg.sv -----
package tcfw_pkg;

    // Field widths of the request and result items
    localparam int CHAR_W     = 8;
    localparam int VROW_W     = 5;
    localparam int VCOL_W     = 7;
    localparam int CCOL_W     = 7;
    localparam int CROW_W     = 5;
    localparam int TOP_W      = 5;
    localparam int ROWS_CFG_W = 6;
    localparam int COLS_CFG_W = 8;
    localparam int CFG_DATA_W = 8;
    localparam int WRAP_W     = 8;

    // Command kinds carried in tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    // Register indexes
    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    // Control characters
    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_FORMFEED  = 8'd12;
    localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;

    localparam logic [WRAP_W-1:0] WRAP_MAX = 8'd255;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_CLEAR_ALL,
        ST_CLEAR_ROW
    } tcfw_state_t;

    // Cell memory access control
    typedef struct packed {
        logic en;
        logic we;
    } ram_req_t;

endpackage

// ----- hw/rtl/tcfw_cell_ram.sv -----
module tcfw_cell_ram
    import tcfw_pkg::*;
#(
    parameter int ADDR_W = 12,
    parameter int DEPTH  = 4096
)
(
    input  logic              clk,
    input  ram_req_t          req,
    input  logic [ADDR_W-1:0] addr,
    input  logic [CHAR_W-1:0] wdata,
    output logic [CHAR_W-1:0] rdata
);

    logic [CHAR_W-1:0] mem [DEPTH];
    logic [CHAR_W-1:0] rdata_reg;

    // Single port: write, or read with registered data
    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            if (req.we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/tcfw_ctrl.sv -----
module tcfw_ctrl
    import tcfw_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_clear,
    input  logic [$clog2(MAX_ROWS+1)-1:0]       eff_rows,
    input  logic [$clog2(MAX_COLS+1)-1:0]       eff_cols,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                command,
    input  logic [CHAR_W-1:0]                   char_code,
    input  logic [VROW_W-1:0]                   view_row,
    input  logic [VCOL_W-1:0]                   view_col,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [CHAR_W-1:0]                   cell_value,
    output logic [CCOL_W-1:0]                   cursor_column,
    output logic [CROW_W-1:0]                   cursor_ring_row,
    output logic [TOP_W-1:0]                    top_ring_row,
    output ram_req_t                            ram_req,
    output logic [$clog2(MAX_ROWS)+$clog2(MAX_COLS)-1:0] ram_addr,
    output logic [CHAR_W-1:0]                   ram_wdata,
    input  logic [CHAR_W-1:0]                   ram_rdata
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RNW = $clog2(MAX_ROWS+1);
    localparam int RW1 = RW + 1;
    localparam logic [RW-1:0] SWEEP_ROW_LAST = RW'(MAX_ROWS - 1);
    localparam logic [CW-1:0] SWEEP_COL_LAST = CW'(MAX_COLS - 1);

    tcfw_state_t state_reg, state_next;

    logic [CW-1:0]     col_reg, col_next;
    logic [RW-1:0]     row_reg, row_next;
    logic [RW-1:0]     top_reg, top_next;
    logic [WRAP_W-1:0] wrap_reg, wrap_next;
    logic [RW-1:0]     sweep_row_reg, sweep_row_next;
    logic [CW-1:0]     sweep_col_reg, sweep_col_next;
    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_cell_reg, out_cell_next;
    logic [CW-1:0]     out_col_reg, out_col_next;
    logic [RW-1:0]     out_row_reg, out_row_next;
    logic [RW-1:0]     out_top_reg, out_top_next;

    // Effect of the offered request on the cursor and the store
    logic [CW-1:0]     n_col;
    logic [RW-1:0]     n_row;
    logic [RW-1:0]     n_top;
    logic [WRAP_W-1:0] n_wrap;
    logic              st_en;
    logic [RW-1:0]     st_row;
    logic [CW-1:0]     st_col;
    logic [CHAR_W-1:0] st_data;
    logic              row_clear;
    logic              full_clear;
    logic              is_read;
    logic              rd_ok;
    logic [RW-1:0]     rd_row;
    logic [CW-1:0]     rd_col;
    logic              accept;
    logic              sweep_done;

    assign accept = in_valid && in_ready;

    // Evaluate the request against the current cursor
    always_comb
    begin : item_eval
        logic [RW-1:0]  rows_last;
        logic [CW-1:0]  cols_last;
        logic [RW-1:0]  row_inc;
        logic [RW-1:0]  row_dec;
        logic [RW-1:0]  top_inc;
        logic [RW1-1:0] rd_sum;
        logic [RW1-1:0] rows_ext;

        rows_last = RW'(eff_rows - RNW'(1));
        cols_last = CW'(eff_cols - 1'b1);
        row_inc   = (row_reg == rows_last) ? '0 : RW'(row_reg + 1'b1);
        row_dec   = (row_reg == '0) ? rows_last : RW'(row_reg - 1'b1);
        top_inc   = (top_reg == rows_last) ? '0 : RW'(top_reg + 1'b1);
        rows_ext  = RW1'(eff_rows);
        rd_sum    = {1'b0, top_reg} + RW1'(RW'(view_row));

        n_col      = col_reg;
        n_row      = row_reg;
        n_top      = top_reg;
        n_wrap     = wrap_reg;
        st_en      = 1'b0;
        st_row     = row_reg;
        st_col     = col_reg;
        st_data    = char_code;
        row_clear  = 1'b0;
        full_clear = 1'b0;
        is_read    = (command == CMD_READ);
        rd_ok      = (32'(view_row) < 32'(eff_rows)) && (32'(view_col) < 32'(eff_cols));
        rd_row     = (rd_sum >= rows_ext) ? RW'(rd_sum - rows_ext) : RW'(rd_sum);
        rd_col     = CW'(view_col);

        if (!is_read)
        begin
            case (char_code)
                CH_BACKSPACE:
                begin
                    if (col_reg != '0)
                    begin
                        n_col = CW'(col_reg - 1'b1);
                    end
                    else if (wrap_reg != '0)
                    begin
                        n_col  = cols_last;
                        n_row  = row_dec;
                        n_wrap = WRAP_W'(wrap_reg - 1'b1);
                    end
                    st_en   = 1'b1;
                    st_row  = n_row;
                    st_col  = n_col;
                    st_data = CH_NUL;
                end
                CH_NEWLINE:
                begin
                    n_col  = '0;
                    n_wrap = '0;
                    n_row  = row_inc;
                    if (row_inc == top_reg)
                    begin
                        n_top     = top_inc;
                        row_clear = 1'b1;
                    end
                end
                CH_FORMFEED:
                begin
                    n_col      = '0;
                    n_row      = '0;
                    n_top      = '0;
                    n_wrap     = '0;
                    full_clear = 1'b1;
                end
                default:
                begin
                    st_en = 1'b1;
                    if (col_reg == cols_last)
                    begin
                        n_col  = '0;
                        n_wrap = (wrap_reg == WRAP_MAX) ? wrap_reg
                                                        : WRAP_W'(wrap_reg + 1'b1);
                        n_row  = row_inc;
                        if (row_inc == top_reg)
                        begin
                            n_top     = top_inc;
                            row_clear = 1'b1;
                        end
                    end
                    else
                    begin
                        n_col = CW'(col_reg + 1'b1);
                    end
                end
            endcase
        end
    end

    assign sweep_done = (sweep_col_reg == SWEEP_COL_LAST) &&
                        ((state_reg == ST_CLEAR_ROW) || (sweep_row_reg == SWEEP_ROW_LAST));

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (is_read && rd_ok)
                    begin
                        state_next = ST_READ;
                    end
                    else if (full_clear)
                    begin
                        state_next = ST_CLEAR_ALL;
                    end
                    else if (row_clear)
                    begin
                        state_next = ST_CLEAR_ROW;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_IDLE;
            end
            ST_CLEAR_ALL, ST_CLEAR_ROW:
            begin
                if (sweep_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_clear)
        begin
            state_next = ST_CLEAR_ALL;
        end
    end

    // Outputs: handshake and memory port
    always_comb
    begin
        in_ready    = 1'b0;
        ram_req.en  = 1'b0;
        ram_req.we  = 1'b0;
        ram_addr    = {st_row, st_col};
        ram_wdata   = st_data;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = !out_valid_reg || out_ready;
                if (is_read)
                begin
                    ram_addr   = {rd_row, rd_col};
                    ram_req.en = accept && rd_ok;
                end
                else
                begin
                    ram_req.en = accept && st_en;
                    ram_req.we = 1'b1;
                end
            end
            ST_CLEAR_ALL, ST_CLEAR_ROW:
            begin
                ram_req.en = 1'b1;
                ram_req.we = 1'b1;
                ram_addr   = {sweep_row_reg, sweep_col_reg};
                ram_wdata  = CH_NUL;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Next values of cursor, sweep counters and result register
    always_comb
    begin
        col_next       = col_reg;
        row_next       = row_reg;
        top_next       = top_reg;
        wrap_next      = wrap_reg;
        sweep_row_next = sweep_row_reg;
        sweep_col_next = sweep_col_reg;
        out_valid_next = out_valid_reg;
        out_cell_next  = out_cell_reg;
        out_col_next   = out_col_reg;
        out_row_next   = out_row_reg;
        out_top_next   = out_top_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Advance the clearing sweep
        if ((state_reg == ST_CLEAR_ALL) || (state_reg == ST_CLEAR_ROW))
        begin
            if (sweep_col_reg == SWEEP_COL_LAST)
            begin
                sweep_col_next = '0;
                if (state_reg == ST_CLEAR_ALL)
                begin
                    sweep_row_next = RW'(sweep_row_reg + 1'b1);
                end
            end
            else
            begin
                sweep_col_next = CW'(sweep_col_reg + 1'b1);
            end
        end

        // Take a request: update cursor and post its result unless a read is due
        if (accept)
        begin
            col_next  = n_col;
            row_next  = n_row;
            top_next  = n_top;
            wrap_next = n_wrap;
            if (full_clear)
            begin
                sweep_row_next = '0;
                sweep_col_next = '0;
            end
            else if (row_clear)
            begin
                sweep_row_next = n_row;
                sweep_col_next = '0;
            end
            if (!(is_read && rd_ok))
            begin
                out_valid_next = 1'b1;
                out_cell_next  = CH_NUL;
                out_col_next   = n_col;
                out_row_next   = n_row;
                out_top_next   = n_top;
            end
        end

        // Post the read result once the memory data is back
        if (state_reg == ST_READ)
        begin
            out_valid_next = 1'b1;
            out_cell_next  = ram_rdata;
            out_col_next   = col_reg;
            out_row_next   = row_reg;
            out_top_next   = top_reg;
        end

        // Home everything on a register write
        if (cfg_clear)
        begin
            col_next       = '0;
            row_next       = '0;
            top_next       = '0;
            wrap_next      = '0;
            sweep_row_next = '0;
            sweep_col_next = '0;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR_ALL;
            col_reg       <= '0;
            row_reg       <= '0;
            top_reg       <= '0;
            wrap_reg      <= '0;
            sweep_row_reg <= '0;
            sweep_col_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            top_reg       <= top_next;
            wrap_reg      <= wrap_next;
            sweep_row_reg <= sweep_row_next;
            sweep_col_reg <= sweep_col_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        out_cell_reg <= out_cell_next;
        out_col_reg  <= out_col_next;
        out_row_reg  <= out_row_next;
        out_top_reg  <= out_top_next;
    end

    assign out_valid       = out_valid_reg;
    assign cell_value      = out_cell_reg;
    assign cursor_column   = CCOL_W'(out_col_reg);
    assign cursor_ring_row = CROW_W'(out_row_reg);
    assign top_ring_row    = TOP_W'(out_top_reg);

endmodule

// ----- hw/rtl/text_console_frame_writer_top.sv -----
// Text console frame writer: a character frame of up to MAX_ROWS x MAX_COLS byte cells held
// as a ring of rows in one single-port synchronous memory. Each request on the slave stream
// (tuser 0 = write a character code, 1 = read a screen cell) gives exactly one result on the
// master stream carrying the cell byte (zero on writes), the cursor column and ring row, and
// the ring row at the top of the screen. Printable bytes, backspace and newline, and a read
// outside the screen, post their result straight into the result register; a read of a cell
// on the screen first waits in ST_READ for the registered memory read data. A scroll that
// reuses the top row zeroes that row, and a form feed, a register write or reset runs a
// clearing pass over all MAX_ROWS x MAX_COLS cells (4096 by default), one cell per cycle
// through the memory port, during which no request is taken. Register writes home the
// cursor and clear the frame; write them only when the block is idle.
module text_console_frame_writer_top
    import tcfw_pkg::*;
#(
    parameter int MAX_ROWS = 32,
    parameter int MAX_COLS = 128
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // char_code[7:0], view_row[12:8], view_col[19:13]
    input  logic                  s_tuser,   // command
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata    // cell_value[7:0], cursor_column[14:8],
                                             // cursor_ring_row[19:15], top_ring_row[24:20]
);

    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int RNW = $clog2(MAX_ROWS+1);
    localparam int CNW = $clog2(MAX_COLS+1);
    localparam int AW  = RW + CW;

    logic [ROWS_CFG_W-1:0] rows_reg;
    logic [COLS_CFG_W-1:0] cols_reg;
    logic [RNW-1:0]        eff_rows;
    logic [CNW-1:0]        eff_cols;

    ram_req_t          ram_req;
    logic [AW-1:0]     ram_addr;
    logic [CHAR_W-1:0] ram_wdata;
    logic [CHAR_W-1:0] ram_rdata;

    logic [CHAR_W-1:0] cell_value;
    logic [CCOL_W-1:0] cursor_column;
    logic [CROW_W-1:0] cursor_ring_row;
    logic [TOP_W-1:0]  top_ring_row;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg <= ROWS_CFG_W'(32);
            cols_reg <= COLS_CFG_W'(128);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_ROWS: rows_reg <= cfg_data[ROWS_CFG_W-1:0];
                CFG_COLS: cols_reg <= cfg_data[COLS_CFG_W-1:0];
                default:  rows_reg <= rows_reg;
            endcase
        end
    end

    // Limit the registers to the supported frame
    always_comb
    begin
        if (rows_reg == '0)
        begin
            eff_rows = RNW'(1);
        end
        else if (32'(rows_reg) > 32'(MAX_ROWS))
        begin
            eff_rows = RNW'(MAX_ROWS);
        end
        else
        begin
            eff_rows = RNW'(rows_reg);
        end

        if (cols_reg == '0)
        begin
            eff_cols = CNW'(1);
        end
        else if (32'(cols_reg) > 32'(MAX_COLS))
        begin
            eff_cols = CNW'(MAX_COLS);
        end
        else
        begin
            eff_cols = CNW'(cols_reg);
        end
    end

    tcfw_ctrl #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_ctrl (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_clear       (cfg_we),
        .eff_rows        (eff_rows),
        .eff_cols        (eff_cols),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .command         (s_tuser),
        .char_code       (s_tdata[7:0]),
        .view_row        (s_tdata[12:8]),
        .view_col        (s_tdata[19:13]),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .cell_value      (cell_value),
        .cursor_column   (cursor_column),
        .cursor_ring_row (cursor_ring_row),
        .top_ring_row    (top_ring_row),
        .ram_req         (ram_req),
        .ram_addr        (ram_addr),
        .ram_wdata       (ram_wdata),
        .ram_rdata       (ram_rdata)
    );

    tcfw_cell_ram #(
        .ADDR_W (AW),
        .DEPTH  (MAX_ROWS << CW)
    ) u_ram (
        .clk   (clk),
        .req   (ram_req),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Pack the result
    assign m_tdata = {7'b0, top_ring_row, cursor_ring_row, cursor_column, cell_value};

endmodule

// ----- hw/rtl/tcfw_checker.sv -----
module tcfw_checker
    import tcfw_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        cfg_we,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [23:0] s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // A write request posts its result on the next cycle with a zero cell
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_WRITE)
        |=> m_tvalid && (m_tdata[7:0] == CH_NUL))
        else $error("write result missing or cell not zero");

    // A form feed homes cursor and top row
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && (s_tuser == CMD_WRITE) && (s_tdata[7:0] == CH_FORMFEED)
        |=> (m_tdata[24:8] == '0))
        else $error("form feed did not home the cursor");

    // A register write starts a clearing pass that blocks requests
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> !s_tready)
        else $error("request taken during clearing pass");

endmodule

bind text_console_frame_writer_top tcfw_checker u_chk (.*);
